[hdl/php_pkg.sv]
`timescale 1ns / 1ps
package php_pkg;

  localparam int unsigned V1_MAX_LINE = 107;
  localparam logic [16:0] MAX_LINE17 = 17'(V1_MAX_LINE);
  localparam logic [16:0] PORT_LIMIT = 17'd65535;

  typedef enum logic [4:0] {
    PH_IDLE, PH_SIG, PH_V1_KW, PH_V1_UNK, PH_V1_TCP, PH_V1_SKIP, PH_V1_SRCA,
    PH_V1_DSTA, PH_V1_SRCP, PH_V1_DSTP, PH_V1_LF, PH_V2_HDR, PH_V2_BODY, PH_DONE
  } phase_e;

  typedef enum logic [1:0] {
    ST_BUSY = 2'd0, ST_PROXIED = 2'd1, ST_SKIPPED = 2'd2, ST_INVALID = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ROLE_OTHER = 2'd0, ROLE_SRC = 2'd1, ROLE_DST = 2'd2
  } role_e;

  localparam logic [1:0] FAM_NONE = 2'd0;
  localparam logic [1:0] FAM_V4   = 2'd1;
  localparam logic [1:0] FAM_V6   = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_flag;
    logic       end_of_data;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]  byte_out;
    logic [1:0]  addr_role;
    logic        addr_binary;
    logic        done_res;
    logic [1:0]  status;
    logic [1:0]  family;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [16:0] header_length;
  } out_beat_t;

  typedef struct packed {
    phase_e      phase;
    logic [16:0] byte_count;
    logic [15:0] body_len;
    logic        v2_ok;
    logic        v1_ok;
    logic        skip;
    logic [1:0]  fam;
    logic [16:0] port_acc;
    logic        port_dig;
    logic        port_bad;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic        saw_cr;
  } parse_st_t;

  function automatic logic [7:0] bin_sig(input logic [3:0] i);
    unique case (i)
      4'd0, 4'd2, 4'd5: bin_sig = 8'h0D;
      4'd1, 4'd3, 4'd6, 4'd11: bin_sig = 8'h0A;
      4'd4: bin_sig = 8'h00;
      4'd7: bin_sig = 8'h51;
      4'd8: bin_sig = 8'h55;
      4'd9: bin_sig = 8'h49;
      4'd10: bin_sig = 8'h54;
      default: bin_sig = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] txt_lead(input logic [2:0] i);
    unique case (i)
      3'd0: txt_lead = "P";
      3'd1: txt_lead = "R";
      3'd2: txt_lead = "O";
      3'd3: txt_lead = "X";
      3'd4: txt_lead = "Y";
      3'd5: txt_lead = " ";
      default: txt_lead = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] txt_unk(input logic [2:0] i);
    unique case (i)
      3'd0: txt_unk = "U";
      3'd1: txt_unk = "N";
      3'd2: txt_unk = "K";
      3'd3: txt_unk = "N";
      3'd4: txt_unk = "O";
      3'd5: txt_unk = "W";
      3'd6: txt_unk = "N";
      default: txt_unk = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] txt_tcp(input logic [1:0] i);
    unique case (i)
      2'd0: txt_tcp = "T";
      2'd1: txt_tcp = "C";
      2'd2: txt_tcp = "P";
      default: txt_tcp = 8'h00;
    endcase
  endfunction

endpackage

[hdl/php_step.sv]
`timescale 1ns / 1ps
module php_step import php_pkg::*; (
  input  parse_st_t st_i,
  input  in_beat_t  in_i,
  output parse_st_t st_o,
  output out_beat_t res_o
);

  parse_st_t   s;
  parse_st_t   n;
  logic [7:0]  ch;
  logic [16:0] pos;
  logic [16:0] k;
  logic [16:0] acc10;
  logic [1:0]  fin;
  logic [1:0]  role;
  logic        bin;
  logic        text_line;
  logic        achar;
  logic        dig;
  logic        v1n;
  logic        v2n;
  logic [15:0] blen;
  logic [16:0] alen;
  logic [16:0] base;
  logic [3:0]  fam4;

  assign ch = in_i.data_byte;
  assign dig = (ch >= "0") && (ch <= "9");
  assign achar = (ch == ":") || (ch == ".") || dig || (ch >= "a" && ch <= "f")
               || (ch >= "A" && ch <= "F");

  always_comb begin
    s = st_i;
    if (in_i.start_flag || st_i.phase == PH_IDLE) begin
      s = '0;
      s.phase = PH_SIG;
      s.v1_ok = 1'b1;
      s.v2_ok = 1'b1;
    end
    n = s;
    fin = ST_BUSY;
    role = ROLE_OTHER;
    bin = 1'b0;
    pos = s.byte_count;
    k = pos - 17'd6;
    acc10 = '0;
    v1n = s.v1_ok;
    v2n = s.v2_ok;
    blen = '0;
    alen = '0;
    base = '0;
    fam4 = ch[7:4];
    text_line = (s.phase >= PH_V1_KW) && (s.phase <= PH_V1_LF);
    if (s.phase != PH_DONE) begin
      n.byte_count = pos + 17'd1;
    end
    unique case (s.phase)
      PH_SIG: begin
        if (pos >= 17'd12) begin
          fin = ST_INVALID;
        end else begin
          if (s.v2_ok && ch != bin_sig(pos[3:0])) v2n = 1'b0;
          if (s.v1_ok && (pos >= 17'd6 || ch != txt_lead(pos[2:0]))) v1n = 1'b0;
          n.v1_ok = v1n;
          n.v2_ok = v2n;
          if (!v1n && !v2n) fin = ST_INVALID;
          else if (pos == 17'd5 && v1n) n.phase = PH_V1_KW;
          else if (pos == 17'd11 && v2n) n.phase = PH_V2_HDR;
        end
      end
      PH_V1_KW: begin
        if (ch == "U") n.phase = PH_V1_UNK;
        else if (ch == "T") n.phase = PH_V1_TCP;
        else fin = ST_INVALID;
      end
      PH_V1_UNK: begin
        if (k >= 17'd7 || ch != txt_unk(k[2:0])) fin = ST_INVALID;
        else if (k == 17'd6) begin
          n.phase = PH_V1_SKIP;
          n.saw_cr = 1'b0;
        end
      end
      PH_V1_TCP: begin
        if (k < 17'd3) begin
          if (ch != txt_tcp(k[1:0])) fin = ST_INVALID;
        end else if (k == 17'd3) begin
          if (ch == "4") n.fam = FAM_V4;
          else if (ch == "6") n.fam = FAM_V6;
          else fin = ST_INVALID;
        end else if (k == 17'd4 && ch == " ") begin
          n.phase = PH_V1_SRCA;
        end else begin
          fin = ST_INVALID;
        end
      end
      PH_V1_SKIP: begin
        if (s.saw_cr && ch == 8'h0A) fin = ST_SKIPPED;
        n.saw_cr = (ch == 8'h0D);
      end
      PH_V1_SRCA, PH_V1_DSTA: begin
        if (ch == " ") begin
          if (s.phase == PH_V1_SRCA) begin
            n.phase = PH_V1_DSTA;
          end else begin
            n.phase = PH_V1_SRCP;
            n.port_acc = '0;
            n.port_dig = 1'b0;
            n.port_bad = 1'b0;
          end
        end else if (achar) begin
          role = (s.phase == PH_V1_SRCA) ? ROLE_SRC : ROLE_DST;
        end else begin
          fin = ST_INVALID;
        end
      end
      PH_V1_SRCP, PH_V1_DSTP: begin
        if (ch == ((s.phase == PH_V1_SRCP) ? 8'h20 : 8'h0D)) begin
          if (s.port_bad || !s.port_dig) begin
            fin = ST_INVALID;
          end else begin
            if (s.phase == PH_V1_SRCP) begin
              n.source_port = s.port_acc[15:0];
              n.phase = PH_V1_DSTP;
            end else begin
              n.dest_port = s.port_acc[15:0];
              n.phase = PH_V1_LF;
            end
            n.port_acc = '0;
            n.port_dig = 1'b0;
            n.port_bad = 1'b0;
          end
        end else if (dig) begin
          if (!s.port_bad) begin
            // accumulator stays <= 65535 here, so x10 + 9 fits in 20 bits
            acc10 = 17'(({3'b0, s.port_acc} << 3) + ({3'b0, s.port_acc} << 1)
                        + 20'(ch - 8'h30));
            n.port_dig = 1'b1;
            if (s.port_acc > 17'd6553 || acc10 > PORT_LIMIT) begin
              n.port_bad = 1'b1;
              n.port_acc = 17'd65536;
            end else begin
              n.port_acc = acc10;
            end
          end
        end else begin
          n.port_bad = 1'b1;
        end
      end
      PH_V1_LF: fin = (ch == 8'h0A) ? ST_PROXIED : ST_INVALID;
      PH_V2_HDR: begin
        if (pos == 17'd12) begin
          if (ch[7:4] != 4'd2) fin = ST_INVALID;
          else n.skip = (ch[3:0] != 4'd1);
        end else if (pos == 17'd13) begin
          if (ch[3:0] != 4'd1 || (fam4 != 4'd1 && fam4 != 4'd2)) n.skip = 1'b1;
          else if (!s.skip) n.fam = fam4[1:0];
        end else if (pos == 17'd14) begin
          n.body_len = {ch, 8'h00};
        end else begin
          blen = s.body_len | {8'h00, ch};
          n.body_len = blen;
          if (!s.skip) begin
            if (blen < ((s.fam == FAM_V4) ? 16'd12 : 16'd36)) fin = ST_INVALID;
            else n.phase = PH_V2_BODY;
          end else if (blen == 16'd0) begin
            fin = ST_SKIPPED;
          end else begin
            n.phase = PH_V2_BODY;
          end
        end
      end
      PH_V2_BODY: begin
        k = pos - 17'd16;
        alen = (s.fam == FAM_V4) ? 17'd4 : 17'd16;
        base = alen << 1;
        if (!s.skip) begin
          if (k < alen) begin
            role = ROLE_SRC;
            bin = 1'b1;
          end else if (k < base) begin
            role = ROLE_DST;
            bin = 1'b1;
          end else if (k == base || k == base + 17'd1) begin
            n.source_port = {s.source_port[7:0], ch};
          end else if (k == base + 17'd2 || k == base + 17'd3) begin
            n.dest_port = {s.dest_port[7:0], ch};
          end
        end
        if (k + 17'd1 >= {1'b0, s.body_len}) fin = s.skip ? ST_SKIPPED : ST_PROXIED;
      end
      PH_DONE: ;
      default: fin = ST_INVALID;
    endcase

    if (s.phase != PH_DONE) begin
      if (fin == ST_BUSY && text_line && n.byte_count >= MAX_LINE17) fin = ST_INVALID;
      if (fin == ST_BUSY && in_i.end_of_data) fin = ST_INVALID;
      if (fin != ST_BUSY) n.phase = PH_DONE;
    end

    res_o = '0;
    res_o.byte_out = ch;
    if (s.phase != PH_DONE) begin
      res_o.addr_role = role;
      res_o.addr_binary = bin;
      if (fin != ST_BUSY) begin
        res_o.done_res = 1'b1;
        res_o.status = fin;
        res_o.header_length = n.byte_count;
        if (fin == ST_PROXIED) begin
          res_o.family = n.fam;
          res_o.source_port = n.source_port;
          res_o.dest_port = n.dest_port;
        end
      end
    end
    st_o = n;
  end

endmodule

[hdl/proxy_header_parser.sv]
`timescale 1ns / 1ps
// Each accepted input beat is parsed combinationally and its result beat is registered, valid in the next cycle.
// Throughput: one beat per cycle; the result register hands off while the next byte
// is parsed, so a stall on the output only holds the input when the register is full.
// Reset: rst_ni is asynchronous active low; parser returns to idle, output empty,
// and the first byte after reset opens a header even without start_flag.
module proxy_header_parser import php_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_data_o
);

  parse_st_t st_q, st_d;
  out_beat_t res_d, res_q;
  logic      vld_q;
  logic      take;

  // Stall the input only when the result register is full and the sink is stalling.
  assign in_stall_o = vld_q && out_stall_i;
  assign take = in_valid_i && !in_stall_o;

  php_step u_step (
    .st_i  (st_q),
    .in_i  (in_data_i),
    .st_o  (st_d),
    .res_o (res_d)
  );

  // Parser state: advance on every accepted beat, hold otherwise.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
      st_q.phase <= PH_IDLE;
    end else if (take) begin
      st_q <= st_d;
    end
  end

  // Result register: fills on an accepted beat, drains when the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (take) begin
      vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = vld_q;
  assign out_data_o  = res_q;

`ifndef NO_ASSERTIONS
  a_done_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.done_res == (out_data_o.status != ST_BUSY)))
    else $error("done flag and status disagree");
  a_done_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && res_d.done_res) |=> (st_q.phase == PH_DONE))
    else $error("parser not closed after deciding beat");
  a_ports_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != ST_PROXIED) |->
      (out_data_o.source_port == 16'd0 && out_data_o.dest_port == 16'd0))
    else $error("ports reported without proxied status");
`endif

endmodule

[test/proxy_header_parser_tb.sv]
`timescale 1ns / 1ps
module proxy_header_parser_tb;
  import php_pkg::*;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;

  proxy_header_parser dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Header constants for the predictor.
  localparam logic [7:0] SIG_BYTES [12] = '{8'h0D, 8'h0A, 8'h0D, 8'h0A, 8'h00, 8'h0D,
                                            8'h0A, 8'h51, 8'h55, 8'h49, 8'h54, 8'h0A};
  localparam logic [7:0] LEAD_BYTES [6] = '{"P", "R", "O", "X", "Y", " "};
  localparam logic [7:0] UNK_BYTES [7] = '{"U", "N", "K", "N", "O", "W", "N"};
  localparam logic [7:0] TCP_BYTES [3] = '{"T", "C", "P"};
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  // Predictor state.
  phase_e      pst;
  logic [16:0] pos_cnt;
  logic [15:0] body_len;
  logic        v2_live, v1_live, skip_body, saw_cr;
  logic [1:0]  fam_seen;
  int          port_acc;
  logic        port_dig, port_bad;
  logic [15:0] sport, dport;

  function automatic void open_header();
    pst = PH_SIG;
    pos_cnt = '0;
    body_len = '0;
    v2_live = 1'b1;
    v1_live = 1'b1;
    skip_body = 1'b0;
    fam_seen = FAM_NONE;
    port_acc = 0;
    port_dig = 1'b0;
    port_bad = 1'b0;
    sport = '0;
    dport = '0;
    saw_cr = 1'b0;
  endfunction

  function automatic bit is_addr_char(logic [7:0] c);
    return c == ":" || c == "." || (c >= "0" && c <= "9") ||
           (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  // Advance the header predictor by one byte and return the result beat it yields.
  function automatic out_beat_t parse_byte(in_beat_t b);
    out_beat_t   o;
    logic [7:0]  c;
    logic [16:0] pos, k, alen, base;
    status_e     fin;
    role_e       role;
    logic        bin, txt;
    o = '0;
    c = b.data_byte;
    fin = ST_BUSY;
    role = ROLE_OTHER;
    bin = 1'b0;
    o.byte_out = c;
    if (b.start_flag || pst == PH_IDLE) open_header();
    if (pst == PH_DONE) return o;
    pos = pos_cnt;
    pos_cnt = pos + 17'd1;
    txt = pst >= PH_V1_KW && pst <= PH_V1_LF;
    case (pst)
      PH_SIG: begin
        if (pos >= 12) fin = ST_INVALID;
        else begin
          if (v2_live && c != SIG_BYTES[pos]) v2_live = 1'b0;
          if (v1_live && (pos >= 6 || c != LEAD_BYTES[pos])) v1_live = 1'b0;
          if (!v1_live && !v2_live) fin = ST_INVALID;
          else if (pos == 5 && v1_live) pst = PH_V1_KW;
          else if (pos == 11 && v2_live) pst = PH_V2_HDR;
        end
      end
      PH_V1_KW: begin
        if (c == "U") pst = PH_V1_UNK;
        else if (c == "T") pst = PH_V1_TCP;
        else fin = ST_INVALID;
      end
      PH_V1_UNK: begin
        k = pos - 17'd6;
        if (k >= 7 || c != UNK_BYTES[k]) fin = ST_INVALID;
        else if (k == 6) begin
          pst = PH_V1_SKIP;
          saw_cr = 1'b0;
        end
      end
      PH_V1_TCP: begin
        k = pos - 17'd6;
        if (k < 3) begin
          if (c != TCP_BYTES[k]) fin = ST_INVALID;
        end else if (k == 3) begin
          if (c == "4") fam_seen = FAM_V4;
          else if (c == "6") fam_seen = FAM_V6;
          else fin = ST_INVALID;
        end else if (k == 4 && c == " ") pst = PH_V1_SRCA;
        else fin = ST_INVALID;
      end
      PH_V1_SKIP: begin
        if (saw_cr && c == CH_LF) fin = ST_SKIPPED;
        saw_cr = (c == CH_CR);
      end
      PH_V1_SRCA, PH_V1_DSTA: begin
        if (c == " ") begin
          if (pst == PH_V1_SRCA) pst = PH_V1_DSTA;
          else begin
            pst = PH_V1_SRCP;
            port_acc = 0;
            port_dig = 1'b0;
            port_bad = 1'b0;
          end
        end else if (is_addr_char(c)) role = (pst == PH_V1_SRCA) ? ROLE_SRC : ROLE_DST;
        else fin = ST_INVALID;
      end
      PH_V1_SRCP, PH_V1_DSTP: begin
        if (c == ((pst == PH_V1_SRCP) ? " " : CH_CR)) begin
          if (port_bad || !port_dig) fin = ST_INVALID;
          else begin
            if (pst == PH_V1_SRCP) begin
              sport = port_acc[15:0];
              pst = PH_V1_DSTP;
            end else begin
              dport = port_acc[15:0];
              pst = PH_V1_LF;
            end
            port_acc = 0;
            port_dig = 1'b0;
            port_bad = 1'b0;
          end
        end else if (c >= "0" && c <= "9") begin
          if (!port_bad) begin
            port_acc = port_acc * 10 + int'(c - "0");
            port_dig = 1'b1;
            if (port_acc > 65535) begin
              port_bad = 1'b1;
              port_acc = 65536;
            end
          end
        end else port_bad = 1'b1;
      end
      PH_V1_LF: fin = (c == CH_LF) ? ST_PROXIED : ST_INVALID;
      PH_V2_HDR: begin
        if (pos == 12) begin
          if (c[7:4] != 4'd2) fin = ST_INVALID;
          else skip_body = (c[3:0] != 4'd1);
        end else if (pos == 13) begin
          if (c[3:0] != 4'd1 || (c[7:4] != 4'd1 && c[7:4] != 4'd2)) skip_body = 1'b1;
          else if (!skip_body) fam_seen = c[5:4];
        end else if (pos == 14) begin
          body_len = {c, 8'h00};
        end else begin
          body_len = body_len | {8'h00, c};
          if (!skip_body) begin
            if (body_len < ((fam_seen == FAM_V4) ? 16'd12 : 16'd36)) fin = ST_INVALID;
            else pst = PH_V2_BODY;
          end else if (body_len == 0) fin = ST_SKIPPED;
          else pst = PH_V2_BODY;
        end
      end
      PH_V2_BODY: begin
        k = pos - 17'd16;
        if (!skip_body) begin
          alen = (fam_seen == FAM_V4) ? 17'd4 : 17'd16;
          base = alen << 1;
          if (k < alen) begin
            role = ROLE_SRC;
            bin = 1'b1;
          end else if (k < base) begin
            role = ROLE_DST;
            bin = 1'b1;
          end else if (k == base || k == base + 1) sport = {sport[7:0], c};
          else if (k == base + 2 || k == base + 3) dport = {dport[7:0], c};
        end
        if (k + 1 >= body_len) fin = skip_body ? ST_SKIPPED : ST_PROXIED;
      end
      default: fin = ST_INVALID;
    endcase
    // Cap the text line, then close on an early end of data.
    if (fin == ST_BUSY && txt && pos_cnt >= MAX_LINE17) fin = ST_INVALID;
    if (fin == ST_BUSY && b.end_of_data) fin = ST_INVALID;
    o.addr_role = role;
    o.addr_binary = bin;
    if (fin != ST_BUSY) begin
      pst = PH_DONE;
      o.done_res = 1'b1;
      o.status = fin;
      if (fin == ST_PROXIED) begin
        o.family = fam_seen;
        o.source_port = sport;
        o.dest_port = dport;
      end
      o.header_length = pos_cnt;
    end
    return o;
  endfunction

  // Beats to send, with per-beat hand-typed expectations and drain points.
  in_beat_t  beats[$];
  bit        typed_row[$];
  out_beat_t typed_want[$];
  bit        drain_first[$];
  out_beat_t expect_q[$];
  int        sent = 0;
  int        n_checked = 0;
  int        n_headers = 0;
  int        n_fail = 0;
  int        cycle = 0;
  int        hold_left = 0;
  bit        hold_done = 1'b0;
  bit        go = 1'b0;
  bit        first_of_hdr;

  function automatic out_beat_t mk_done(logic [7:0] c, status_e st, logic [16:0] len);
    out_beat_t o;
    o = '0;
    o.byte_out = c;
    o.done_res = 1'b1;
    o.status = st;
    o.header_length = len;
    return o;
  endfunction

  function automatic out_beat_t mk_echo(logic [7:0] c);
    out_beat_t o;
    o = '0;
    o.byte_out = c;
    return o;
  endfunction

  function automatic void add_beat(logic [7:0] c, bit sf, bit eod, bit typed = 0,
                                   out_beat_t want = '0, bit drain = 0);
    in_beat_t b;
    b.data_byte = c;
    b.start_flag = sf;
    b.end_of_data = eod;
    beats.push_back(b);
    typed_row.push_back(typed);
    typed_want.push_back(want);
    drain_first.push_back(drain);
  endfunction

  // Random-content header assembly: the first byte carries start, some bytes get
  // corrupted or cut short with end of data.
  function automatic void add_byte(logic [7:0] c);
    bit eod;
    if ($urandom_range(99) < 3) c = 8'($urandom);
    eod = ($urandom_range(199) == 0);
    add_beat(c, first_of_hdr, eod);
    first_of_hdr = 1'b0;
  endfunction

  function automatic void add_str(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic string rand_addr();
    string chars, s;
    int n, idx;
    chars = "0123456789abcdefABCDEF:.";
    s = "";
    n = $urandom_range(15);
    for (int i = 0; i < n; i++) begin
      idx = $urandom_range(23);
      s = {s, chars.substr(idx, idx)};
    end
    return s;
  endfunction

  function automatic string rand_port();
    case ($urandom_range(9))
      0: return "";
      1: return "65535";
      2: return "65536";
      3: return $sformatf("00%0d", $urandom_range(999));
      4: return $sformatf("%0dx", $urandom_range(99));
      5: return $sformatf("%0d", $urandom_range(99999));
      default: return $sformatf("%0d", $urandom_range(65535));
    endcase
  endfunction

  function automatic void build_random_header();
    int kind, n, blen;
    logic [7:0] fam_b;
    first_of_hdr = 1'b1;
    kind = $urandom_range(99);
    n_headers++;
    if (kind < 40) begin
      add_str($urandom_range(1) ? "PROXY TCP4 " : "PROXY TCP6 ");
      add_str({rand_addr(), " ", rand_addr(), " ", rand_port(), " ", rand_port()});
      add_byte(CH_CR);
      add_byte(CH_LF);
    end else if (kind < 55) begin
      add_str("PROXY UNKNOWN");
      n = $urandom_range(8);
      for (int i = 0; i < n; i++) add_byte(8'($urandom_range(32, 126)));
      if ($urandom_range(3) == 0) add_byte(CH_CR);
      add_byte(CH_CR);
      add_byte(CH_LF);
    end else if (kind < 90) begin
      for (int i = 0; i < 12; i++) add_byte(SIG_BYTES[i]);
      add_byte(($urandom_range(9) == 0) ? 8'($urandom) : 8'h21);
      case ($urandom_range(9))
        0: fam_b = 8'($urandom);
        1: fam_b = 8'h31;
        2, 3, 4: fam_b = 8'h21;
        default: fam_b = 8'h11;
      endcase
      if ($urandom_range(7) == 0) blen = $urandom_range(40);
      else blen = ((fam_b == 8'h21) ? 36 : 12) + $urandom_range(5);
      add_byte(8'(blen >> 8));
      add_byte(8'(blen));
      for (int i = 0; i < blen; i++) add_byte(8'($urandom));
    end else begin
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) add_byte(8'($urandom));
    end
    // Sometimes one trailing byte after the header: echoed only if the header has decided.
    if ($urandom_range(3) == 0) add_byte(8'($urandom));
  endfunction

  function automatic void report_field(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $error("%s mismatch: expected %0d, got %0d", name, e, a);
      n_fail++;
    end
  endfunction

  // Drive the input side: predict on every accepted beat, then offer the next one.
  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    if (in_valid && !in_stall) begin
      out_beat_t exp;
      exp = parse_byte(in_data);
      if (typed_row[sent]) exp = typed_want[sent];
      expect_q.push_back(exp);
      sent = sent + 1;
    end
    if (go && (!in_valid || !in_stall)) begin
      // Hold at a drain point until every result is back; idle now and then
      // except in the calm window.
      if (sent >= beats.size() || (drain_first[sent] && expect_q.size() != 0) ||
          ((cycle < 1500 || cycle > 2500) && $urandom_range(99) < 6)) begin
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        in_data <= beats[sent];
      end
    end
  end

  // Drive the output stall: one long hold-off to back up the block, random otherwise.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!hold_done && sent >= 300) begin
      hold_done <= 1'b1;
      hold_left <= 200;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (cycle < 1500 || cycle > 2500) && ($urandom_range(99) < 6);
    end
  end

  // Check each accepted result beat against the oldest expectation.
  always @(posedge clk_i) begin
    if (out_valid && !out_stall) begin
      if (expect_q.size() == 0) begin
        $error("result beat with no expectation pending: byte %0d", out_data.byte_out);
        n_fail++;
      end else begin
        out_beat_t exp;
        exp = expect_q.pop_front();
        report_field("byte_out", exp.byte_out, out_data.byte_out);
        report_field("addr_role", exp.addr_role, out_data.addr_role);
        report_field("addr_binary", exp.addr_binary, out_data.addr_binary);
        report_field("done_res", exp.done_res, out_data.done_res);
        report_field("status", exp.status, out_data.status);
        report_field("family", exp.family, out_data.family);
        report_field("source_port", exp.source_port, out_data.source_port);
        report_field("dest_port", exp.dest_port, out_data.dest_port);
        report_field("header_length", exp.header_length, out_data.header_length);
        n_checked++;
      end
    end
  end

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    pst = PH_IDLE;
    open_header();
    pst = PH_IDLE;
    // Directed: first byte after reset opens a header without start, then echo only.
    add_beat("Z", 0, 0, 1, mk_done("Z", ST_INVALID, 17'd1));
    add_beat(8'hFF, 0, 0, 1, mk_echo(8'hFF));
    add_beat(8'h00, 1, 0);
    add_beat(8'hFF, 1, 0, 1, mk_done(8'hFF, ST_INVALID, 17'd1));
    // Binary LOCAL command with an empty body: skipped on the last length byte.
    for (int i = 0; i < 12; i++) add_beat(SIG_BYTES[i], i == 0, 0);
    add_beat(8'h20, 0, 0);
    add_beat(8'h00, 0, 0);
    add_beat(8'h00, 0, 0);
    add_beat(8'h00, 0, 0, 1, mk_done(8'h00, ST_SKIPPED, 17'd16));
    // Data ends on the first byte.
    add_beat("P", 1, 1, 1, mk_done("P", ST_INVALID, 17'd1));
    drain_first[drain_first.size() - 1] = 1'b0;
    n_headers = 0;
    while (beats.size() < 650) begin
      int here;
      here = beats.size();
      build_random_header();
      if (here == 21 || (here > 450 && here < 480)) drain_first[here] = 1'b1;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    go <= 1'b1;
    wait (sent == beats.size());
    wait (expect_q.size() == 0);
    repeat (10) @(posedge clk_i);
    $display("Sent %0d bytes in %0d random headers plus directed cases; %0d result beats checked.",
             beats.size(), n_headers, n_checked);
    if (n_fail == 0 && expect_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
